>>> hdl/rdtpc_pkg.sv
package rdtpc_pkg;

    localparam int unsigned HdrBytes = 9;
    localparam logic [16:0] CountMax = 17'h1FFFF;
    localparam logic [15:0] SumGood  = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FLAG_DATA  = 2'd0;
    localparam logic [1:0] REG_FLAG_ACK   = 2'd1;
    localparam logic [1:0] REG_FLAG_FIN   = 2'd2;
    localparam logic [1:0] REG_BIG_ENDIAN = 2'd3;

    // verdict codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_FLAGS = 3'd2;
    localparam logic [2:0] ST_LEN_MISS  = 3'd3;
    localparam logic [2:0] ST_CSUM_FAIL = 3'd4;

    typedef struct packed {
        logic [7:0] flag_data_code;
        logic [7:0] flag_ack_code;
        logic [7:0] flag_fin_code;
        logic       big_endian_fields;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_end;
        logic [2:0]  status;
        logic [31:0] seq_number;
        logic [7:0]  packet_flags;
        logic [15:0] payload_length;
    } t_result;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> hdl/rdtpc_cfg_regs.sv
module rdtpc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output rdtpc_pkg::t_cfg   o_cfg
);

    rdtpc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_data_code    <= 8'd1;
            r_cfg.flag_ack_code     <= 8'd2;
            r_cfg.flag_fin_code     <= 8'd4;
            r_cfg.big_endian_fields <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rdtpc_pkg::REG_FLAG_DATA:  r_cfg.flag_data_code    <= i_cfg_data;
                rdtpc_pkg::REG_FLAG_ACK:   r_cfg.flag_ack_code     <= i_cfg_data;
                rdtpc_pkg::REG_FLAG_FIN:   r_cfg.flag_fin_code     <= i_cfg_data;
                rdtpc_pkg::REG_BIG_ENDIAN: r_cfg.big_endian_fields <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/rdtpc_parse.sv
module rdtpc_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdtpc_pkg::t_cfg      i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_res_ready,
    output logic                 o_res_valid,
    output rdtpc_pkg::t_result   o_res
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // packet state
    logic [16:0] r_count, n_count;
    logic [15:0] r_sum,   n_sum;
    logic [7:0]  r_pend,  n_pend;
    logic [31:0] r_seq,   n_seq;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_len,   n_len;

    logic        advance;
    logic        is_payload;
    logic [15:0] addend;
    logic [15:0] sum_add;
    logic [16:0] data_len;
    logic        flags_ok;
    logic [2:0]  status;

    assign advance    = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_comb begin
        is_payload = r_count >= 17'(rdtpc_pkg::HdrBytes);

        n_seq   = r_seq;
        n_flags = r_flags;
        n_len   = r_len;
        if (r_count < 17'd4) begin
            n_seq = i_cfg.big_endian_fields ? {r_seq[23:0], r_in_byte}
                                            : {r_in_byte, r_seq[31:8]};
        end else if (r_count == 17'd4) begin
            n_flags = r_in_byte;
        end else if (r_count == 17'd7 || r_count == 17'd8) begin
            n_len = i_cfg.big_endian_fields ? {r_len[7:0], r_in_byte}
                                            : {r_in_byte, r_len[15:8]};
        end

        // odd byte pairs with the held high byte; even final byte pads low
        addend  = r_count[0] ? {r_pend, r_in_byte} : {r_in_byte, 8'h00};
        sum_add = rdtpc_pkg::ones_add(r_sum, addend);

        n_pend = r_count[0] ? r_pend : r_in_byte;
        n_sum  = r_count[0] ? sum_add : r_sum;

        n_count  = (r_count < rdtpc_pkg::CountMax) ? r_count + 17'd1 : rdtpc_pkg::CountMax;
        data_len = n_count - 17'(rdtpc_pkg::HdrBytes);

        flags_ok = n_flags == i_cfg.flag_data_code || n_flags == i_cfg.flag_ack_code ||
                   n_flags == i_cfg.flag_fin_code;

        if (n_count < 17'(rdtpc_pkg::HdrBytes)) begin
            status = rdtpc_pkg::ST_SHORT;
        end else if (!flags_ok) begin
            status = rdtpc_pkg::ST_BAD_FLAGS;
        end else if ({1'b0, n_len} != data_len) begin
            status = rdtpc_pkg::ST_LEN_MISS;
        end else if (sum_add != rdtpc_pkg::SumGood) begin
            status = rdtpc_pkg::ST_CSUM_FAIL;
        end else begin
            status = rdtpc_pkg::ST_OK;
        end

        o_res_valid          = advance && (is_payload || r_in_last);
        o_res.payload_byte   = is_payload ? r_in_byte : 8'h00;
        o_res.payload_valid  = is_payload;
        o_res.packet_end     = r_in_last;
        o_res.status         = r_in_last ? status : rdtpc_pkg::ST_OK;
        if (r_in_last && status != rdtpc_pkg::ST_SHORT) begin
            o_res.seq_number     = n_seq;
            o_res.packet_flags   = n_flags;
            o_res.payload_length = n_len;
        end else begin
            o_res.seq_number     = 32'd0;
            o_res.packet_flags   = 8'd0;
            o_res.payload_length = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= '0;
            r_seq   <= '0;
            r_flags <= '0;
            r_len   <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_pend  <= '0;
                r_seq   <= '0;
                r_flags <= '0;
                r_len   <= '0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_pend  <= n_pend;
                r_seq   <= n_seq;
                r_flags <= n_flags;
                r_len   <= n_len;
            end
        end
    end

endmodule

>>> hdl/rdtpc_out_stage.sv
module rdtpc_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    output logic                 o_res_ready,
    input  rdtpc_pkg::t_result   i_res,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser
);

    logic               r_valid;
    rdtpc_pkg::t_result r_res;

    assign o_res_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_res.payload_length, r_res.packet_flags,
                            r_res.seq_number, r_res.status, r_res.payload_byte};
    assign m_axis_tlast  = r_res.packet_end;
    assign m_axis_tuser  = r_res.payload_valid;

endmodule

>>> hdl/rdt_packet_checker_core.sv
// Packet checker: takes a packet one byte per transfer on the slave stream (tlast on the
// final byte), parses the 9-byte header (4-byte sequence number, flags byte, 2-byte
// checksum, 2-byte payload length), forwards every payload byte as a master transfer and
// keeps a running 16-bit ones-complement sum over the whole packet, odd final byte padded
// low. The final byte gives one transfer with tlast high carrying the verdict: too short,
// flags not one of the three codes, declared length mismatch, checksum failure, checked in
// that order. Header bytes that are not final give no transfer. One byte is taken every
// cycle unless the sink stalls, since the only work between the input register and the
// result register is one 16-bit end-around add and a few compares; a byte goes through
// the input register and then the result register; a stalled sink holds both. The user
// must write configuration only while no packet byte is in flight; no logic enforces it.
module rdt_packet_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // packet bytes in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
    input  logic        s_axis_tlast,   // last_byte
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                        // [42:11] seq_number, [50:43] packet_flags,
                                        // [66:51] payload_length, [71:67] zero
    output logic        m_axis_tlast,   // packet_end
    output logic        m_axis_tuser    // payload_valid
);

    rdtpc_pkg::t_cfg    cfg;
    rdtpc_pkg::t_result res;
    logic               res_valid;
    logic               res_ready;

    // flag codes and field byte order
    rdtpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register, header capture, running sum and verdict
    rdtpc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register, holds a transfer while the sink stalls
    rdtpc_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .o_res_ready   (res_ready),
        .i_res         (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;      // settling wait after the last expected result
    localparam int LONG_HOLD    = 300;    // receiver hold-off that fills the pipeline

    // receiver stall patterns
    typedef enum logic [1:0] {RX_ALWAYS, RX_LIGHT, RX_PATTERN, RX_HEAVY} t_rx_mode;

    // one packet byte waiting to be sent
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;    // hold this byte back until no result is still due
    } t_byte_xfer;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] packet_byte
    logic        s_axis_tlast;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // [7:0] payload_byte, [10:8] status, [42:11] seq_number,
                                  // [50:43] packet_flags, [66:51] payload_length
    logic        m_axis_tlast;    // packet_end
    logic        m_axis_tuser;    // payload_valid

    rdt_packet_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // checker state mirrored by the predictor
    rdtpc_pkg::t_cfg cfg_now;
    logic [16:0] pos_count;
    logic [15:0] run_sum;
    logic [7:0]  high_byte;
    logic [31:0] seq_acc;
    logic [7:0]  flags_acc;
    logic [15:0] len_acc;

    rdtpc_pkg::t_result due_results[$];    // verdicts and payload bytes still to come
    t_byte_xfer  tx_items[$];       // bytes not yet offered
    logic [7:0]  pkt_buf[$];        // packet under construction

    // sender state
    t_byte_xfer  cur_item;
    bit          tx_taken;
    bit          tx_idle_en;
    bit          nxt_valid;
    int          burst_left;
    int          gap_left;

    // receiver state
    t_rx_mode    rx_mode;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          rx_tick;
    logic        nxt_ready;

    int          cycles;
    int          fail_count;
    rdtpc_pkg::t_result want;

    // 16-bit ones-complement add, end-around carry
    function automatic logic [15:0] csum_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // advance the mirrored checker by one accepted byte, queue what it gives
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [16:0] p;
        logic        payload;
        logic [15:0] s;
        logic [2:0]  st;
        logic        flags_ok;
        rdtpc_pkg::t_result r;
        p       = pos_count;
        payload = (p >= 17'(rdtpc_pkg::HdrBytes));
        // header capture, byte order taken as it is right now
        if (p < 17'd4) begin
            if (cfg_now.big_endian_fields) seq_acc = {seq_acc[23:0], b};
            else seq_acc = {b, seq_acc[31:8]};
        end else if (p == 17'd4) begin
            flags_acc = b;
        end else if (p == 17'd7 || p == 17'd8) begin
            if (cfg_now.big_endian_fields) len_acc = {len_acc[7:0], b};
            else len_acc = {b, len_acc[15:8]};
        end
        // pair bytes high/low into words
        if (!p[0]) high_byte = b;
        else run_sum = csum_fold(run_sum, {high_byte, b});
        pos_count = (p < rdtpc_pkg::CountMax) ? p + 17'd1 : rdtpc_pkg::CountMax;

        r = '0;
        if (payload) begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
        end
        if (last) begin
            s = run_sum;
            if (!p[0]) s = csum_fold(s, {b, 8'h00});    // odd final byte, padded low
            flags_ok = flags_acc == cfg_now.flag_data_code ||
                       flags_acc == cfg_now.flag_ack_code ||
                       flags_acc == cfg_now.flag_fin_code;
            if (pos_count < 17'(rdtpc_pkg::HdrBytes)) st = rdtpc_pkg::ST_SHORT;
            else if (!flags_ok) st = rdtpc_pkg::ST_BAD_FLAGS;
            else if ({1'b0, len_acc} != pos_count - 17'(rdtpc_pkg::HdrBytes))
                st = rdtpc_pkg::ST_LEN_MISS;
            else if (s != rdtpc_pkg::SumGood) st = rdtpc_pkg::ST_CSUM_FAIL;
            else st = rdtpc_pkg::ST_OK;
            r.packet_end = 1'b1;
            r.status     = st;
            if (st != rdtpc_pkg::ST_SHORT) begin
                r.seq_number     = seq_acc;
                r.packet_flags   = flags_acc;
                r.payload_length = len_acc;
            end
            pos_count = '0;
            run_sum   = '0;
            high_byte = '0;
            seq_acc   = '0;
            flags_acc = '0;
            len_acc   = '0;
        end
        if (payload || last) due_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // build a whole packet with a good checksum unless corrupt is set
    task automatic make_packet(input logic [31:0] seq, input logic [7:0] flags,
                               input int plen, input logic [15:0] decl,
                               input logic big, input bit corrupt);
        logic [15:0] s;
        logic [15:0] x;
        int          i;
        pkt_buf.delete();
        for (i = 0; i < 4; i++)
            pkt_buf.push_back(big ? seq[8*(3-i) +: 8] : seq[8*i +: 8]);
        pkt_buf.push_back(flags);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(big ? decl[15:8] : decl[7:0]);
        pkt_buf.push_back(big ? decl[7:0] : decl[15:8]);
        for (i = 0; i < plen; i++) pkt_buf.push_back(8'($urandom));
        s = '0;
        for (i = 0; i < pkt_buf.size(); i += 2)
            s = csum_fold(s, {pkt_buf[i], (i + 1 < pkt_buf.size()) ? pkt_buf[i+1] : 8'h00});
        // checksum bytes straddle two words, so the field lands byte-swapped
        x = ~s;
        if (corrupt) x = x ^ 16'($urandom_range(1, 65535));
        pkt_buf[5] = x[7:0];
        pkt_buf[6] = x[15:8];
    endtask

    // queue bytes from..to of the packet buffer, tlast on the buffer's final byte
    task automatic send_buf(input int from, input int to, input bit drain);
        t_byte_xfer it;
        int         i;
        for (i = from; i <= to; i++) begin
            it.data  = pkt_buf[i];
            it.last  = (i == pkt_buf.size() - 1);
            it.drain = drain && (i == from);
            tx_items.push_back(it);
        end
    endtask

    task automatic queue_random_packet(output int nbytes);
        logic [31:0] seq;
        logic [7:0]  flags;
        logic [15:0] decl;
        int          plen;
        int          i;
        if ($urandom_range(0, 99) < 18) begin
            // noise: short or malformed byte runs
            pkt_buf.delete();
            plen = $urandom_range(1, 14);
            for (i = 0; i < plen; i++) pkt_buf.push_back(8'($urandom));
        end else begin
            seq = $urandom;
            case ($urandom_range(0, 9)) inside
                [0:2]:   flags = cfg_now.flag_data_code;
                [3:4]:   flags = cfg_now.flag_ack_code;
                [5:6]:   flags = cfg_now.flag_fin_code;
                default: flags = 8'($urandom);
            endcase
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 12);
            decl = 16'(plen);
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       decl = decl + 16'd1;
                    1:       decl = decl - 16'd1;
                    default: decl = 16'($urandom);
                endcase
            end
            make_packet(seq, flags, plen, decl, cfg_now.big_endian_fields,
                        $urandom_range(0, 6) == 0);
        end
        send_buf(0, pkt_buf.size() - 1, $urandom_range(0, 11) == 0);
        nbytes = pkt_buf.size();
    endtask

    // nothing queued, nothing offered, nothing expected, then let the pipe settle
    task automatic wait_idle();
        while (tx_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rdtpc_pkg::REG_FLAG_DATA:  cfg_now.flag_data_code    = val;
            rdtpc_pkg::REG_FLAG_ACK:   cfg_now.flag_ack_code     = val;
            rdtpc_pkg::REG_FLAG_FIN:   cfg_now.flag_fin_code     = val;
            rdtpc_pkg::REG_BIG_ENDIAN: cfg_now.big_endian_fields = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int nbytes, input t_rx_mode mode,
                                    input bit idle, input bit long_hold);
        int queued;
        int n;
        rx_mode    = mode;
        tx_idle_en = idle;
        queued     = 0;
        while (queued < nbytes) begin
            queue_random_packet(n);
            queued += n;
        end
        // receiver holds off while the sender keeps offering
        if (long_hold) hold_requests++;
        wait_idle();
    endtask

    // sender: bursts and gaps, byte held until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (s_axis_tvalid && !tx_taken) begin
            nxt_valid = 1'b1;
        end else begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (tx_items.size() != 0 &&
                         !(tx_items[0].drain && due_results.size() != 0)) begin
                cur_item  = tx_items.pop_front();
                nxt_valid = 1'b1;
                if (tx_idle_en) begin
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        tx_taken = 1'b0;
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= cur_item.data;
        s_axis_tlast  <= cur_item.last;
    end

    // input transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_byte(cur_item.data, cur_item.last);
            tx_taken = 1'b1;
        end
    end

    // receiver: stall pattern per phase, long hold-off on request
    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_served != hold_requests) begin
            hold_left = LONG_HOLD;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  nxt_ready = 1'b1;
                RX_LIGHT:   nxt_ready = ($urandom_range(0, 9) > 2);
                RX_PATTERN: nxt_ready = ((rx_tick % 7) < 4);
                default:    nxt_ready = ($urandom_range(0, 9) > 6);
            endcase
        end
        m_axis_tready <= nxt_ready;
    end

    // output transfers checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("payload_byte", 32'(want.payload_byte),
                            32'(m_axis_tdata[7:0]));
                check_field("payload_valid", 32'(want.payload_valid), 32'(m_axis_tuser));
                check_field("packet_end", 32'(want.packet_end), 32'(m_axis_tlast));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[10:8]));
                check_field("seq_number", want.seq_number, m_axis_tdata[42:11]);
                check_field("packet_flags", 32'(want.packet_flags),
                            32'(m_axis_tdata[50:43]));
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_axis_tdata[66:51]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cur_item      = '{data: 8'h00, last: 1'b0, drain: 1'b0};
        tx_taken      = 1'b0;
        tx_idle_en    = 1'b1;
        burst_left    = 0;
        gap_left      = 0;
        rx_mode       = RX_LIGHT;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        rx_tick       = 0;
        cycles        = 0;
        fail_count    = 0;
        cfg_now       = '{flag_data_code: 8'd1, flag_ack_code: 8'd2,
                          flag_fin_code: 8'd4, big_endian_fields: 1'b0};
        pos_count     = '0;
        run_sum       = '0;
        high_byte     = '0;
        seq_acc       = '0;
        flags_acc     = '0;
        len_acc       = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset codes: too short, payload on the final byte, bad flags
        pkt_buf.delete();
        pkt_buf.push_back(8'h00);
        send_buf(0, 0, 1'b0);
        make_packet(32'h0000_0000, cfg_now.flag_data_code, 1, 16'd1, 1'b0, 1'b0);
        send_buf(0, pkt_buf.size() - 1, 1'b0);
        make_packet(32'hFFFF_FFFF, 8'hFF, 0, 16'hFFFF, 1'b0, 1'b0);
        send_buf(0, pkt_buf.size() - 1, 1'b0);
        wait_idle();

        run_random_phase(320, RX_LIGHT, 1'b1, 1'b0);

        // extreme codes, big-endian fields, long receiver hold-off
        cfg_write(rdtpc_pkg::REG_FLAG_DATA, 8'h00);
        cfg_write(rdtpc_pkg::REG_FLAG_ACK, 8'hFF);
        cfg_write(rdtpc_pkg::REG_FLAG_FIN, 8'h80);
        cfg_write(rdtpc_pkg::REG_BIG_ENDIAN, 8'hFF);
        run_random_phase(320, RX_PATTERN, 1'b1, 1'b1);

        // all three codes equal, little-endian, no idling on either side
        cfg_write(rdtpc_pkg::REG_FLAG_DATA, 8'h55);
        cfg_write(rdtpc_pkg::REG_FLAG_ACK, 8'h55);
        cfg_write(rdtpc_pkg::REG_FLAG_FIN, 8'h55);
        cfg_write(rdtpc_pkg::REG_BIG_ENDIAN, 8'hFE);
        run_random_phase(300, RX_ALWAYS, 1'b0, 1'b0);

        // random codes, byte order flipped in the middle of the sequence number
        cfg_write(rdtpc_pkg::REG_FLAG_DATA, 8'($urandom));
        cfg_write(rdtpc_pkg::REG_FLAG_ACK, 8'($urandom));
        cfg_write(rdtpc_pkg::REG_FLAG_FIN, 8'($urandom));
        rx_mode    = RX_LIGHT;
        tx_idle_en = 1'b1;
        make_packet($urandom, cfg_now.flag_ack_code, 3, 16'd3, 1'b0, 1'b0);
        send_buf(0, 2, 1'b0);
        wait_idle();
        cfg_write(rdtpc_pkg::REG_BIG_ENDIAN, 8'h01);
        send_buf(3, pkt_buf.size() - 1, 1'b0);
        wait_idle();
        run_random_phase(300, RX_HEAVY, 1'b1, 1'b0);

        cfg_write(rdtpc_pkg::REG_FLAG_DATA, 8'hFF);
        cfg_write(rdtpc_pkg::REG_FLAG_ACK, 8'hFF);
        cfg_write(rdtpc_pkg::REG_FLAG_FIN, 8'h00);
        cfg_write(rdtpc_pkg::REG_BIG_ENDIAN, 8'h01);
        run_random_phase(300, RX_LIGHT, 1'b1, 1'b1);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
